### sv/inversion_counter_unit_macros.svh
// Assertion macros shared by the inversion counter RTL.
// No dependencies; each RTL file that checks itself includes this header.
`ifndef INVERSION_COUNTER_UNIT_MACROS_SVH
`define INVERSION_COUNTER_UNIT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define IC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("inversion counter: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define IC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("inversion counter: next-cycle check failed");
`else
`define IC_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define IC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### sv/ic_pkg.sv
// Shared constants and types for the inversion counter.
// No dependencies; used by ic_cell and inversion_counter_unit.
package ic_pkg;

    localparam int MAX_ITEMS_DEF  = 256;
    localparam int VALUE_BITS_DEF = 32;

    localparam int ADDED_W = 8;
    localparam int TOTAL_W = 15;

    localparam int ADDED_MAX = 255;
    localparam int TOTAL_MAX = 32767;

    // Control bits that travel with a word along the cell row
    typedef struct packed {
        logic valid;
        logic last;
        logic ovf;
    } ic_ctl_t;

endpackage

### sv/ic_cell.sv
// One compare cell of the inversion counter row: holds one stored key.
// Depends on ic_pkg (ic_ctl_t).
module ic_cell import ic_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int CNT_W      = 9,
    parameter int GRT_W      = 8,
    parameter int CELL_IDX   = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  ic_ctl_t               in_ctl,
    input  logic [VALUE_BITS-1:0] in_key,
    input  logic [CNT_W-1:0]      in_cnt,
    input  logic [GRT_W-1:0]      in_grt,
    output ic_ctl_t               out_ctl,
    output logic [VALUE_BITS-1:0] out_key,
    output logic [CNT_W-1:0]      out_cnt,
    output logic [GRT_W-1:0]      out_grt
);

    ic_ctl_t               ctl_reg;
    logic [VALUE_BITS-1:0] key_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [GRT_W-1:0]      grt_reg;
    logic [VALUE_BITS-1:0] stored_reg;

    logic [GRT_W-1:0]      grt_next;
    logic                  occupied;
    logic                  store_here;

    // The word's own array count says which cells belong to its array
    assign occupied   = in_cnt > CNT_W'(CELL_IDX);
    assign store_here = in_ctl.valid && (in_cnt == CNT_W'(CELL_IDX));

    always_comb begin
        grt_next = in_grt;
        if (in_ctl.valid && occupied && (stored_reg > in_key)) begin
            grt_next = in_grt + GRT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (adv) begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            key_reg <= in_key;
            cnt_reg <= in_cnt;
            grt_reg <= grt_next;
            if (store_here) begin
                stored_reg <= in_key;
            end
        end
    end

    assign out_ctl = ctl_reg;
    assign out_key = key_reg;
    assign out_cnt = cnt_reg;
    assign out_grt = grt_reg;

endmodule

### sv/inversion_counter_unit.sv
// Top level of the streaming inversion counter: a row of compare cells and
// the result stage. Depends on ic_pkg, ic_cell and inversion_counter_unit_macros.svh.

// Inversion counter. Accepts one array element per word on the s_ channel
// and returns one result word per element on the m_ channel, in order: how
// many earlier elements of the same array are strictly greater (saturating
// at 255), the running total (saturating at 32767), an overflow flag for an
// element that came past MAX_ITEMS stored ones (not stored, not counted) and
// done_res, which repeats last and marks the final total of the array.
// Values are the low VALUE_BITS bits of s_value, two's complement.
// The element walks along a row of MAX_ITEMS cells, one cell per cycle while
// the row advances; each cell holds one earlier element and adds one to the
// travelling count when its element is greater. The element is written into
// the first cell past the current array's count. Words follow each other a
// cell apart, so a new element is taken every cycle unless m_ready stalls the
// row (one element per cycle sustained). The accepted element passes through
// the MAX_ITEMS cell registers and then the result register, which drives
// m_valid. A stall on m_ready freezes the whole row.
// s_ready is low while aresetn is asserted.
// No clearing pass: each word carries its array's count, so cells from an
// earlier array are simply ignored after a last element.
module inversion_counter_unit import ic_pkg::*; #(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_value,
    input  logic                  s_last,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ADDED_W-1:0]    m_added,
    output logic [TOTAL_W-1:0]    m_total,
    output logic                  m_overflow,
    output logic                  m_done_res
);

`include "inversion_counter_unit_macros.svh"

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int GRT_W = $clog2(MAX_ITEMS);
    localparam int SUM_W = ((GRT_W > TOTAL_W) ? GRT_W : TOTAL_W) + 1;

    // Row taps: index 0 is the entry, index MAX_ITEMS the tail
    ic_ctl_t               ctl_tap [0:MAX_ITEMS];
    logic [VALUE_BITS-1:0] key_tap [0:MAX_ITEMS];
    logic [CNT_W-1:0]      cnt_tap [0:MAX_ITEMS];
    logic [GRT_W-1:0]      grt_tap [0:MAX_ITEMS];

    logic                  adv;
    logic                  s_fire;
    logic                  full;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;

    logic [TOTAL_W-1:0]    total_reg;
    logic [TOTAL_W-1:0]    total_next;
    logic                  m_valid_reg;
    logic [ADDED_W-1:0]    m_added_reg;
    logic [TOTAL_W-1:0]    m_total_reg;
    logic                  m_overflow_reg;
    logic                  m_done_reg;

    ic_ctl_t               tail_ctl;
    logic                  tail_fire;
    logic [SUM_W-1:0]      grt_ext;
    logic [SUM_W-1:0]      sum;
    logic [ADDED_W-1:0]    added_sat;
    logic [TOTAL_W-1:0]    total_sat;

    // The row moves whenever the result register is free or being emptied;
    // no word is taken while in reset
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv && aresetn;
    assign s_fire  = s_valid && s_ready;

    // ---------------- entry: array element count ----------------
    assign full = (cnt_reg == CNT_W'(MAX_ITEMS));

    always_comb begin
        cnt_next = cnt_reg;
        if (s_fire) begin
            if (s_last) begin
                cnt_next = '0;
            end else if (!full) begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Flipping the sign bit turns signed order into unsigned order
    assign ctl_tap[0].valid = s_valid;
    assign ctl_tap[0].last  = s_last;
    assign ctl_tap[0].ovf   = full;
    assign key_tap[0] = s_value ^ {1'b1, {(VALUE_BITS-1){1'b0}}};
    assign cnt_tap[0] = cnt_reg;
    assign grt_tap[0] = '0;

    // ---------------- row of compare cells ----------------
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        ic_cell #(
            .VALUE_BITS (VALUE_BITS),
            .CNT_W      (CNT_W),
            .GRT_W      (GRT_W),
            .CELL_IDX   (g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .in_ctl  (ctl_tap[g]),
            .in_key  (key_tap[g]),
            .in_cnt  (cnt_tap[g]),
            .in_grt  (grt_tap[g]),
            .out_ctl (ctl_tap[g+1]),
            .out_key (key_tap[g+1]),
            .out_cnt (cnt_tap[g+1]),
            .out_grt (grt_tap[g+1])
        );
    end

    // ---------------- tail: saturation and running total ----------------
    assign tail_ctl  = ctl_tap[MAX_ITEMS];
    assign tail_fire = adv && tail_ctl.valid;

    assign grt_ext = SUM_W'(grt_tap[MAX_ITEMS]);
    assign sum     = SUM_W'(total_reg) + grt_ext;

    always_comb begin
        added_sat = (grt_ext > SUM_W'(ADDED_MAX)) ? ADDED_W'(ADDED_MAX) : grt_ext[ADDED_W-1:0];
        total_sat = (sum >= SUM_W'(TOTAL_MAX)) ? TOTAL_W'(TOTAL_MAX) : sum[TOTAL_W-1:0];
        if (tail_ctl.ovf) begin
            added_sat = '0;
            total_sat = total_reg;
        end
    end

    // Running total restarts after the last element of an array
    always_comb begin
        total_next = total_reg;
        if (tail_fire) begin
            total_next = tail_ctl.last ? '0 : total_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            total_reg <= total_next;
            if (adv) begin
                m_valid_reg <= tail_ctl.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tail_fire) begin
            m_added_reg    <= added_sat;
            m_total_reg    <= total_sat;
            m_overflow_reg <= tail_ctl.ovf;
            m_done_reg     <= tail_ctl.last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_added    = m_added_reg;
    assign m_total    = m_total_reg;
    assign m_overflow = m_overflow_reg;
    assign m_done_res = m_done_reg;

    // ---------------- checks ----------------
    `IC_ASSERT_SAME(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(MAX_ITEMS))
    `IC_ASSERT_NEXT(a_last_clears, aclk, aresetn, s_fire && s_last, cnt_reg == '0)
    `IC_ASSERT_SAME(a_ovf_no_add, aclk, aresetn, m_valid && m_overflow, m_added == '0)
    `IC_ASSERT_NEXT(a_total_grows, aclk, aresetn, !(tail_fire && tail_ctl.last),
                    total_reg >= $past(total_reg))

endmodule

### dv/tb_inversion_counter_unit.sv
// Self-checking testbench for inversion_counter_unit: random valid/ready traffic on both sides,
// with each result word checked against an in-bench running inversion count.
// Depends on ic_pkg and the inversion_counter_unit RTL only.
module tb_inversion_counter_unit;
    import ic_pkg::*;

    localparam int DEPTH       = MAX_ITEMS_DEF;
    localparam int VBITS       = VALUE_BITS_DEF;
    localparam int LATENCY     = DEPTH + 1;     // row length plus the result register
    localparam int ITEM_TARGET = 1200;
    localparam int STALL_LIMIT = 4000;          // cycles with no word moving on either side
    localparam int MAX_REPORTS = 30;

    localparam logic [VBITS-1:0] VMAX = {1'b0, {(VBITS-1){1'b1}}};
    localparam logic [VBITS-1:0] VMIN = {1'b1, {(VBITS-1){1'b0}}};

    // Value patterns used to build arrays
    typedef enum logic [2:0] {
        FILL_WIDE,      // any value
        FILL_NARROW,    // a handful of values, so plenty of ties
        FILL_RISING,    // non-decreasing: no inversions
        FILL_FALLING,   // non-increasing: many inversions
        FILL_EDGE       // values at and next to the ends of the range, and -1, 0 and 1
    } fill_kind_t;

    typedef struct packed {
        logic [VBITS-1:0] value;
        logic             last;
    } element_t;

    typedef struct packed {
        logic [ADDED_W-1:0] added;
        logic [TOTAL_W-1:0] total;
        logic               overflow;
        logic               done_res;
    } tally_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [VBITS-1:0]   s_value = '0;
    logic               s_last  = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [ADDED_W-1:0] m_added;
    logic [TOTAL_W-1:0] m_total;
    logic               m_overflow;
    logic               m_done_res;

    inversion_counter_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .s_last     (s_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_added    (m_added),
        .m_total    (m_total),
        .m_overflow (m_overflow),
        .m_done_res (m_done_res)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Running inversion count, advanced once per accepted input word
    // ------------------------------------------------------------------
    logic signed [VBITS-1:0] kept_values [DEPTH];
    int unsigned             kept_count = 0;
    int unsigned             array_total = 0;

    element_t pending_q [$];    // words still to be offered on s_
    tally_t   tally_q   [$];    // results owed on m_, oldest first

    int unsigned words_queued = 0;
    int unsigned words_in     = 0;
    int unsigned words_out    = 0;
    int unsigned arrays_ended = 0;
    int unsigned ovf_words    = 0;
    int unsigned peak_total   = 0;
    int unsigned err_count    = 0;

    // Compares the new element with every one kept so far in this array,
    // then stores it. Past capacity nothing is stored or counted.
    function automatic tally_t count_inversions(element_t e);
        tally_t      r;
        int unsigned greater;
        r       = '0;
        greater = 0;
        if (kept_count >= DEPTH) begin
            r.overflow = 1'b1;
        end else begin
            for (int unsigned i = 0; i < kept_count; i++) begin
                if (kept_values[i] > $signed(e.value))
                    greater++;
            end
            kept_values[kept_count] = e.value;
            kept_count++;
            r.added = ADDED_W'((greater > ADDED_MAX) ? ADDED_MAX : greater);
            if (greater >= TOTAL_MAX - array_total)
                array_total = TOTAL_MAX;
            else
                array_total = array_total + greater;
        end
        r.total    = TOTAL_W'(array_total);
        r.done_res = e.last;
        // last ends the array even on an ignored word
        if (e.last) begin
            kept_count  = 0;
            array_total = 0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Idle patterns: mode 0 never idles, 1 short gaps, 2 adds long ones
    // ------------------------------------------------------------------
    int unsigned in_mode   = 0;
    int unsigned out_mode  = 0;
    int unsigned mode_tick = 0;

    function automatic int unsigned pick_gap(int unsigned mode);
        int unsigned roll;
        if (mode == 0)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return (mode == 2) ? $urandom_range(8, 40) : $urandom_range(4, 8);
    endfunction

    always @(posedge aclk) begin
        mode_tick <= mode_tick + 1;
        if (mode_tick % 200 == 0) begin
            in_mode  <= $urandom_range(0, 2);
            out_mode <= $urandom_range(0, 2);
        end
    end

    // ------------------------------------------------------------------
    // s_ driver: offers pending words; the tally is taken at acceptance
    // ------------------------------------------------------------------
    int unsigned in_gap = 0;
    element_t    next_word;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            in_gap  <= 0;
        end else begin
            if (s_valid && s_ready) begin
                tally_q.push_back(count_inversions('{s_value, s_last}));
                words_in++;
            end
            // valid is only touched once the current word has gone
            if (!s_valid || s_ready) begin
                if (in_gap != 0) begin
                    in_gap  <= in_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    next_word = pending_q.pop_front();
                    s_value   <= next_word.value;
                    s_last    <= next_word.last;
                    s_valid   <= 1'b1;
                    in_gap    <= pick_gap(in_mode);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // m_ side: random back-pressure and the result check
    // ------------------------------------------------------------------
    int unsigned out_stall = 0;
    tally_t      want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            out_stall <= 0;
        end else if (out_stall != 0) begin
            m_ready   <= 1'b0;
            out_stall <= out_stall - 1;
        end else begin
            m_ready   <= 1'b1;
            out_stall <= pick_gap(out_mode);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            words_out++;
            if (tally_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: result word with none outstanding: added=%0d total=%0d ovf=%0b done=%0b",
                             $time, m_added, m_total, m_overflow, m_done_res);
            end else begin
                want = tally_q.pop_front();
                if (m_done_res)
                    arrays_ended++;
                if (m_overflow)
                    ovf_words++;
                if (m_total > peak_total)
                    peak_total = m_total;
                if (m_added !== want.added || m_total !== want.total ||
                    m_overflow !== want.overflow || m_done_res !== want.done_res) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: word %0d mismatch: expected added=%0d total=%0d ovf=%0b done=%0b, got added=%0d total=%0d ovf=%0b done=%0b",
                                 $time, words_out, want.added, want.total, want.overflow,
                                 want.done_res, m_added, m_total, m_overflow, m_done_res);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: nothing moving on either side for too long
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired, %0d results still owed", $time, tally_q.size());
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_word(logic [VBITS-1:0] v, logic last);
        pending_q.push_back('{v, last});
        words_queued++;
    endtask

    function automatic logic [VBITS-1:0] edge_value();
        case ($urandom_range(0, 6))
            0:       return VMIN;
            1:       return VMAX;
            2:       return VMIN + 1;
            3:       return VMAX - 1;
            4:       return '1;
            5:       return 1;
            default: return '0;
        endcase
    endfunction

    task automatic queue_array(int unsigned len, fill_kind_t kind);
        logic [VBITS-1:0] v;
        v = $urandom_range(0, 2000) - 1000;
        for (int unsigned i = 0; i < len; i++) begin
            case (kind)
                FILL_WIDE:    v = $urandom;
                FILL_NARROW:  v = $urandom_range(0, 6) - 3;
                FILL_RISING:  v = v + $urandom_range(0, 3);
                FILL_FALLING: v = v - $urandom_range(0, 3);
                default:      v = edge_value();
            endcase
            queue_word(v, i == len - 1);
        end
    endtask

    // Sampled on the falling edge, clear of the updates at the rising one
    task automatic wait_drained();
        while (pending_q.size() != 0 || s_valid || tally_q.size() != 0)
            @(negedge aclk);
    endtask

    int unsigned array_len;
    bit          mid_pause_done = 0;

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: single-word array, range ends, ties, sign, bit patterns
        queue_word('0, 1'b1);
        queue_word(VMAX, 1'b0);
        queue_word(VMIN, 1'b0);
        queue_word('0, 1'b0);
        queue_word('1, 1'b0);
        queue_word(VMAX, 1'b0);
        queue_word(VMIN, 1'b1);
        queue_word(5, 1'b0);
        queue_word(5, 1'b0);
        queue_word(5, 1'b1);
        queue_word(3, 1'b0);
        queue_word(2, 1'b0);
        queue_word(1, 1'b0);
        queue_word(0, 1'b1);
        queue_word(1, 1'b0);
        queue_word('1, 1'b1);
        queue_word({(VBITS/2){2'b10}}, 1'b0);
        queue_word({(VBITS/2){2'b01}}, 1'b0);
        queue_word(VMIN + 1, 1'b0);
        queue_word(VMAX - 1, 1'b1);
        wait_drained();

        // Capacity: strictly falling full array gives the largest added and
        // total, then words past capacity, the last of them closing the array
        for (int unsigned i = 0; i < DEPTH; i++)
            queue_word(VMAX - i, 1'b0);
        queue_word(VMIN, 1'b0);
        queue_word(VMAX, 1'b0);
        queue_word('0, 1'b1);
        // next array must start clean
        queue_word(7, 1'b0);
        queue_word(3, 1'b1);

        // Random arrays; mostly short, now and then one around capacity
        while (words_queued < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 4)
                array_len = $urandom_range(DEPTH - 2, DEPTH + 6);
            else
                array_len = $urandom_range(1, 24);
            queue_array(array_len, fill_kind_t'($urandom_range(0, 4)));
            if (!mid_pause_done && words_queued >= ITEM_TARGET / 2) begin
                // hold the sender until every owed result is back
                wait_drained();
                mid_pause_done = 1;
            end
        end

        wait_drained();
        repeat (LATENCY + 16) @(posedge aclk);

        if (tally_q.size() != 0) begin
            err_count++;
            $display("%0t: %0d results never arrived", $time, tally_q.size());
        end
        $display("Sent %0d elements, %0d arrays closed, %0d words past capacity, peak total %0d.",
                 words_in, arrays_ended, ovf_words, peak_total);
        $display("Checked %0d result words, %0d errors.", words_out, err_count);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
